/* hdl/crdr_pkg.sv */
// Shared constants and command type for the colour range damage ratio block.
package crdr_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned GRADE_W = 2;
  localparam int unsigned CNT_W   = 23;
  localparam int unsigned TOT_W   = CNT_W + 1;
  localparam int unsigned QUO_W   = PCT_W;
  // Quotient never exceeds 100, so seven restoring steps are enough.
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
  // Dividend is damaged * 100, which stays below 2^30.
  localparam int unsigned REM_W   = CNT_W + 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CNT_W-1:0]   COUNT_MAX    = '1;
  localparam logic [CH_W-1:0]    MASK_IN      = 8'd255;
  localparam logic [CH_W-1:0]    MASK_OUT     = 8'd0;
  localparam logic [CH_W-1:0]    MASK_DAMAGED = 8'd120;
  localparam logic [CH_W-1:0]    LOWER_RESET  = 8'd0;
  localparam logic [CH_W-1:0]    UPPER_RESET  = 8'd255;
  localparam logic [PCT_W-1:0]   HIGH_RESET   = 7'd50;
  localparam logic [PCT_W-1:0]   LOW_RESET    = 7'd30;
  localparam logic [GRADE_W-1:0] GRADE_LIGHT  = 2'd0;
  localparam logic [GRADE_W-1:0] GRADE_MIDDLE = 2'd1;
  localparam logic [GRADE_W-1:0] GRADE_SEVERE = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWER_CH0 = 3'd0,
    CFG_LOWER_CH1 = 3'd1,
    CFG_LOWER_CH2 = 3'd2,
    CFG_UPPER_CH0 = 3'd3,
    CFG_UPPER_CH1 = 3'd4,
    CFG_UPPER_CH2 = 3'd5,
    CFG_GRADE_HI  = 3'd6,
    CFG_GRADE_LO  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic pix_accept;  // a pixel transfer happens this cycle
    logic out_pixel;   // load the output register with a plain pixel result
    logic load_rem;    // prepare dividend and divisor
    logic div_step;    // one restoring division step
    logic sum_load;    // load the output register with the frame summary
  } cmd_t;

endpackage

/* hdl/crdr_ctrl.sv */
// Controller state machine: handshakes, division sequencing and output valid.
module crdr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_frame_last_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output crdr_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_WAIT
  } state_e;

  state_e                      state_q;
  logic [crdr_pkg::STEP_W-1:0] step_q;
  logic                        out_valid_q;
  logic                        out_valid_d;
  logic                        out_free;
  logic                        accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // The output register fills on a plain pixel or on the summary, and
  // otherwise empties once its transfer has gone.
  assign out_valid_d = (accept && !in_frame_last_i) ||
                       ((state_q == ST_WAIT) && out_free) ||
                       (out_valid_q && !out_ready_i);

  always_comb begin
    cmd_o            = '0;
    cmd_o.pix_accept = accept;
    cmd_o.out_pixel  = accept && !in_frame_last_i;
    cmd_o.load_rem   = (state_q == ST_LOAD);
    cmd_o.div_step   = (state_q == ST_DIV);
    cmd_o.sum_load   = (state_q == ST_WAIT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && in_frame_last_i) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          step_q  <= crdr_pkg::STEP_W'(crdr_pkg::DIV_STEPS - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (step_q == '0) begin
            state_q <= ST_WAIT;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        ST_WAIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hdl/crdr_dp.sv */
// Datapath: configuration, range test, counters, restoring divider and output register.
module crdr_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [crdr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [crdr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [crdr_pkg::CH_W-1:0]         pix_ch0_i,
  input  logic [crdr_pkg::CH_W-1:0]         pix_ch1_i,
  input  logic [crdr_pkg::CH_W-1:0]         pix_ch2_i,
  input  logic                              frame_first_i,
  input  crdr_pkg::cmd_t                    cmd_i,
  output logic [crdr_pkg::CH_W-1:0]         mask_value_o,
  output logic                              summary_valid_o,
  output logic [crdr_pkg::PCT_W-1:0]        damage_pct_o,
  output logic [crdr_pkg::GRADE_W-1:0]      grade_o,
  output logic                              empty_count_o
);

  localparam int unsigned COL_W = 3 * crdr_pkg::CH_W;

  logic [crdr_pkg::CH_W-1:0]  lo0_q, lo1_q, lo2_q, up0_q, up1_q, up2_q;
  logic [crdr_pkg::PCT_W-1:0] hi_pct_q, lo_pct_q;
  logic [COL_W-1:0]           bg_q;
  logic [crdr_pkg::CNT_W-1:0] dmg_q, good_q;

  logic [crdr_pkg::CNT_W-1:0] dvd_q;
  logic [crdr_pkg::TOT_W-1:0] tot_q;
  logic [crdr_pkg::REM_W-1:0] rem_q, dsr_q;
  logic [crdr_pkg::QUO_W-1:0] quo_q;
  logic                       empty_q;
  logic [crdr_pkg::CH_W-1:0]  mask_pend_q;

  logic [crdr_pkg::CH_W-1:0]    mask_q;
  logic                         sum_valid_q;
  logic [crdr_pkg::PCT_W-1:0]   pct_q;
  logic [crdr_pkg::GRADE_W-1:0] grade_q;
  logic                         empty_out_q;

  logic [COL_W-1:0]           colour, bg_eff;
  logic [crdr_pkg::CNT_W-1:0] dmg_base, good_base, dmg_new, good_new;
  logic                       in_range, differs;
  logic [crdr_pkg::CH_W-1:0]  mask;
  logic [crdr_pkg::PCT_W-1:0] pct;
  logic [crdr_pkg::GRADE_W-1:0] grade;
  logic                       rem_ge;

  always_comb begin
    colour    = {pix_ch2_i, pix_ch1_i, pix_ch0_i};
    bg_eff    = frame_first_i ? colour : bg_q;
    dmg_base  = frame_first_i ? '0 : dmg_q;
    good_base = frame_first_i ? '0 : good_q;
    in_range  = (pix_ch0_i >= lo0_q) && (pix_ch0_i <= up0_q) &&
                (pix_ch1_i >= lo1_q) && (pix_ch1_i <= up1_q) &&
                (pix_ch2_i >= lo2_q) && (pix_ch2_i <= up2_q);
    differs   = (colour != bg_eff);
    dmg_new   = dmg_base;
    good_new  = good_base;
    mask      = in_range ? crdr_pkg::MASK_IN : crdr_pkg::MASK_OUT;
    if (differs) begin
      if (in_range) begin
        if (good_base != crdr_pkg::COUNT_MAX) begin
          good_new = good_base + 1'b1;
        end
      end else begin
        if (dmg_base != crdr_pkg::COUNT_MAX) begin
          dmg_new = dmg_base + 1'b1;
        end
        mask = crdr_pkg::MASK_DAMAGED;
      end
    end
  end

  assign rem_ge = (rem_q >= dsr_q);

  always_comb begin
    pct = empty_q ? '0 : quo_q;
    if (pct > hi_pct_q) begin
      grade = crdr_pkg::GRADE_SEVERE;
    end else if (pct < lo_pct_q) begin
      grade = crdr_pkg::GRADE_LIGHT;
    end else begin
      grade = crdr_pkg::GRADE_MIDDLE;
    end
  end

  // Configuration registers and frame state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo0_q    <= crdr_pkg::LOWER_RESET;
      lo1_q    <= crdr_pkg::LOWER_RESET;
      lo2_q    <= crdr_pkg::LOWER_RESET;
      up0_q    <= crdr_pkg::UPPER_RESET;
      up1_q    <= crdr_pkg::UPPER_RESET;
      up2_q    <= crdr_pkg::UPPER_RESET;
      hi_pct_q <= crdr_pkg::HIGH_RESET;
      lo_pct_q <= crdr_pkg::LOW_RESET;
      bg_q     <= '0;
      dmg_q    <= '0;
      good_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (crdr_pkg::cfg_idx_e'(cfg_idx_i))
          crdr_pkg::CFG_LOWER_CH0: lo0_q    <= cfg_data_i;
          crdr_pkg::CFG_LOWER_CH1: lo1_q    <= cfg_data_i;
          crdr_pkg::CFG_LOWER_CH2: lo2_q    <= cfg_data_i;
          crdr_pkg::CFG_UPPER_CH0: up0_q    <= cfg_data_i;
          crdr_pkg::CFG_UPPER_CH1: up1_q    <= cfg_data_i;
          crdr_pkg::CFG_UPPER_CH2: up2_q    <= cfg_data_i;
          crdr_pkg::CFG_GRADE_HI:  hi_pct_q <= cfg_data_i[crdr_pkg::PCT_W-1:0];
          crdr_pkg::CFG_GRADE_LO:  lo_pct_q <= cfg_data_i[crdr_pkg::PCT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.pix_accept) begin
        if (frame_first_i) begin
          bg_q <= colour;
        end
        if (cmd_i.out_pixel) begin
          dmg_q  <= dmg_new;
          good_q <= good_new;
        end else begin
          // Last pixel of the frame: counts restart after the summary.
          dmg_q  <= '0;
          good_q <= '0;
        end
      end
    end
  end

  // Divider and output payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_accept && !cmd_i.out_pixel) begin
      dvd_q       <= dmg_new;
      tot_q       <= crdr_pkg::TOT_W'(dmg_new) + crdr_pkg::TOT_W'(good_new);
      mask_pend_q <= mask;
    end
    if (cmd_i.load_rem) begin
      // damaged * 100 as (d << 6) + (d << 5) + (d << 2).
      rem_q   <= (crdr_pkg::REM_W'(dvd_q) << 6) + (crdr_pkg::REM_W'(dvd_q) << 5) +
                 (crdr_pkg::REM_W'(dvd_q) << 2);
      dsr_q   <= crdr_pkg::REM_W'(tot_q) << (crdr_pkg::DIV_STEPS - 1);
      empty_q <= (tot_q == '0);
      quo_q   <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= rem_q - dsr_q;
      end
      quo_q <= {quo_q[crdr_pkg::QUO_W-2:0], rem_ge};
      dsr_q <= dsr_q >> 1;
    end
    if (cmd_i.out_pixel) begin
      mask_q      <= mask;
      sum_valid_q <= 1'b0;
      pct_q       <= '0;
      grade_q     <= crdr_pkg::GRADE_LIGHT;
      empty_out_q <= 1'b0;
    end else if (cmd_i.sum_load) begin
      mask_q      <= mask_pend_q;
      sum_valid_q <= 1'b1;
      pct_q       <= pct;
      grade_q     <= grade;
      empty_out_q <= empty_q;
    end
  end

  assign mask_value_o    = mask_q;
  assign summary_valid_o = sum_valid_q;
  assign damage_pct_o    = pct_q;
  assign grade_o         = grade_q;
  assign empty_count_o   = empty_out_q;

endmodule

/* hdl/color_range_damage_ratio.sv */
// Top level of the colour range damage ratio block.
// Each pixel transfer is judged against the configured per-channel bounds and
// the background colour latched from the frame's first pixel, and gives one
// result transfer carrying its mask value. Ordinary pixels are taken one per
// cycle while results are taken, with the output register decoupling the two
// sides. The last pixel of a frame starts the summary: a load state forms
// damaged*100 and the divisor, then a restoring divider produces the
// percentage one quotient bit per cycle, and a wait state hands the summary
// to the output register once the previous result is taken; only then is the next pixel accepted.
module color_range_damage_ratio (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [crdr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [crdr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [crdr_pkg::CH_W-1:0]          pix_ch0_i,
  input  logic [crdr_pkg::CH_W-1:0]          pix_ch1_i,
  input  logic [crdr_pkg::CH_W-1:0]          pix_ch2_i,
  input  logic                               frame_first_i,
  input  logic                               frame_last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [crdr_pkg::CH_W-1:0]          mask_value_o,
  output logic                               summary_valid_o,
  output logic [crdr_pkg::PCT_W-1:0]         damage_pct_o,
  output logic [crdr_pkg::GRADE_W-1:0]       grade_o,
  output logic                               empty_count_o
);

  crdr_pkg::cmd_t cmd;

  crdr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_frame_last_i (frame_last_i),
    .in_ready_o      (in_ready_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cmd_o           (cmd)
  );

  crdr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .pix_ch0_i       (pix_ch0_i),
    .pix_ch1_i       (pix_ch1_i),
    .pix_ch2_i       (pix_ch2_i),
    .frame_first_i   (frame_first_i),
    .cmd_i           (cmd),
    .mask_value_o    (mask_value_o),
    .summary_valid_o (summary_valid_o),
    .damage_pct_o    (damage_pct_o),
    .grade_o         (grade_o),
    .empty_count_o   (empty_count_o)
  );

endmodule
